@@ rtl/core/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Combinational invariant, checked at every clock edge out of reset.
`define MSTT_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Condition in one cycle implies consequence in the next.
`define MSTT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/mstt_pkg.sv @@
package mstt_pkg;

  localparam int NUM_SLOTS_DEF = 16;
  localparam int QUEUE_DEPTH   = 2;

  localparam int ID_W    = 32;
  localparam int MS_W    = 27;
  localparam int STAMP_W = 48;
  localparam int EL_W    = 32;
  localparam int INTV_W  = 37;
  localparam int REM_W   = 38;
  localparam int STAT_W  = 3;

  localparam logic [MS_W-1:0] MAX_DURATION_MS = 27'd86400000;
  localparam logic [9:0]      US_PER_MS       = 10'd1000;

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_INVALID = 3'd1;
  localparam logic [STAT_W-1:0] ST_BUDGET  = 3'd2;
  localparam logic [STAT_W-1:0] ST_FIRED   = 3'd3;
  localparam logic [STAT_W-1:0] ST_NONE    = 3'd4;

  typedef enum logic [1:0] {
    KIND_IMM,
    KIND_START,
    KIND_CANCEL,
    KIND_TICK
  } job_kind_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_FINISH
  } back_state_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic [MS_W-1:0]    duration_ms;
    logic               repeat_req;
    logic [ID_W-1:0]    cancel_id;
    logic [STAMP_W-1:0] time_stamp;
    logic [EL_W-1:0]    elapsed_us;
  } cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   timer_id;
    logic              last;
  } rsp_t;

  typedef struct packed {
    job_kind_t         kind;
    logic [STAT_W-1:0] status;
    logic              periodic;
    logic [INTV_W-1:0] interval;
    logic [ID_W-1:0]   cancel_id;
    logic [EL_W-1:0]   elapsed_us;
  } job_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [REM_W-1:0]  remaining;
    logic [INTV_W-1:0] interval;
    logic              periodic;
  } slot_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

@@ rtl/core/mstt_front.sv @@
module mstt_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  mstt_pkg::cmd_t    cmd,
  input  mstt_pkg::q_status_t q_status,
  output logic              push,
  output mstt_pkg::job_t    job
);
  import mstt_pkg::*;

  logic [STAMP_W-1:0] last_stamp;
  logic               stamp_valid;
  logic               accept;

  assign cmd_stall = q_status.full;
  assign accept    = cmd_valid && !q_status.full;
  assign push      = accept;

  always_comb begin
    job.kind       = KIND_IMM;
    job.status     = ST_NONE;
    job.periodic   = cmd.repeat_req;
    job.interval   = {{(INTV_W-MS_W){1'b0}}, cmd.duration_ms} *
                     {{(INTV_W-10){1'b0}}, US_PER_MS};
    job.cancel_id  = cmd.cancel_id;
    job.elapsed_us = cmd.elapsed_us;
    case (cmd.operation)
      OP_START: begin
        if (cmd.duration_ms > MAX_DURATION_MS) begin
          job.status = ST_INVALID;
        end else begin
          job.kind = KIND_START;
        end
      end
      OP_CANCEL: begin
        if (cmd.cancel_id == '0) begin
          job.status = ST_OK;
        end else begin
          job.kind = KIND_CANCEL;
        end
      end
      OP_TICK: begin
        if (stamp_valid && (cmd.time_stamp != last_stamp)) begin
          job.kind = KIND_TICK;
        end
      end
      default: begin
        job.kind = KIND_IMM;
      end
    endcase
  end

  // record the stamp of every tick transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      stamp_valid <= 1'b0;
      last_stamp  <= '0;
    end else if (accept && (cmd.operation == OP_TICK)) begin
      stamp_valid <= 1'b1;
      last_stamp  <= cmd.time_stamp;
    end
  end

endmodule

@@ rtl/core/mstt_queue.sv @@
`include "assert_macros.svh"

module mstt_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  mstt_pkg::job_t      wr_job,
  input  logic                pop,
  output mstt_pkg::job_t      rd_job,
  output mstt_pkg::q_status_t status
);
  import mstt_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign status.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign rd_job       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `MSTT_ASSERT(a_no_push_full, !(push && status.full), "push into full queue")
  `MSTT_ASSERT(a_no_pop_empty, !(pop && status.empty), "pop from empty queue")

endmodule

@@ rtl/core/mstt_back.sv @@
`include "assert_macros.svh"

module mstt_back #(
  parameter int NUM_SLOTS = mstt_pkg::NUM_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  mstt_pkg::q_status_t q_status,
  input  mstt_pkg::job_t      head,
  output logic                pop,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output mstt_pkg::rsp_t      rsp
);
  import mstt_pkg::*;

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  back_state_t        state;
  back_state_t        state_next;
  logic [IDX_W-1:0]   idx;
  job_t               cur;
  logic [NUM_SLOTS-1:0] act;
  slot_t              slot_mem [NUM_SLOTS];
  slot_t              rd;
  logic [ID_W-1:0]    next_id;
  logic [ID_W-1:0]    next_id_next;
  logic               pend_v;
  logic [ID_W-1:0]    pend_id;

  logic               load;
  logic               step;
  logic               want_emit;
  logic               emit;
  rsp_t               item;
  logic               done;
  logic               wr_en;
  slot_t              wr_data;
  logic               act_set;
  logic               act_clr;
  logic               id_adv;
  logic               pend_load;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               out_free;
  logic               is_last;
  logic               match;
  logic               due;
  logic [REM_W-1:0]   new_rem;

  assign out_free = !rsp_valid || !rsp_stall;
  assign is_last  = (idx == IDX_W'(NUM_SLOTS - 1));
  assign new_rem  = rd.remaining - {{(REM_W-EL_W){1'b0}}, cur.elapsed_us};
  assign due      = new_rem[REM_W-1] || (new_rem == '0);
  assign match    = act[idx] && (rd.id == cur.cancel_id);

  always_comb begin
    next_id_next = next_id + 1'b1;
    if (next_id_next == '0) begin
      next_id_next = {{(ID_W-1){1'b0}}, 1'b1};
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (load) begin
          state_next = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (step && done) begin
          state_next = BK_IDLE;
        end else if (step && is_last) begin
          state_next = BK_FINISH;
        end
      end
      BK_FINISH: begin
        if (step) begin
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    load      = 1'b0;
    want_emit = 1'b0;
    item      = '0;
    done      = 1'b0;
    wr_en     = 1'b0;
    wr_data   = rd;
    act_set   = 1'b0;
    act_clr   = 1'b0;
    id_adv    = 1'b0;
    pend_load = 1'b0;
    case (state)
      BK_IDLE: begin
        if (!q_status.empty) begin
          if (head.kind == KIND_IMM) begin
            want_emit     = 1'b1;
            item.status   = head.status;
            item.last     = 1'b1;
            pop           = out_free;
          end else begin
            pop  = 1'b1;
            load = 1'b1;
          end
        end
      end
      BK_SCAN: begin
        case (cur.kind)
          KIND_START: begin
            if (!act[idx]) begin
              want_emit         = 1'b1;
              item.status       = ST_OK;
              item.timer_id     = next_id_next;
              item.last         = 1'b1;
              done              = 1'b1;
              wr_en             = 1'b1;
              wr_data.id        = next_id_next;
              wr_data.remaining = {1'b0, cur.interval};
              wr_data.interval  = cur.interval;
              wr_data.periodic  = cur.periodic;
              act_set           = 1'b1;
              id_adv            = 1'b1;
            end else if (is_last) begin
              want_emit   = 1'b1;
              item.status = ST_BUDGET;
              item.last   = 1'b1;
              done        = 1'b1;
            end
          end
          KIND_CANCEL: begin
            if (match || is_last) begin
              want_emit   = 1'b1;
              item.status = ST_OK;
              item.last   = 1'b1;
              done        = 1'b1;
              act_clr     = match;
            end
          end
          KIND_TICK: begin
            if (act[idx]) begin
              wr_en             = 1'b1;
              wr_data.remaining = new_rem;
              if (due) begin
                pend_load = 1'b1;
                if (rd.periodic) begin
                  wr_data.remaining = {1'b0, rd.interval};
                end else begin
                  act_clr = 1'b1;
                end
                if (pend_v) begin
                  want_emit     = 1'b1;
                  item.status   = ST_FIRED;
                  item.timer_id = pend_id;
                end
              end
            end
          end
          default: begin
            done = 1'b1;
          end
        endcase
      end
      BK_FINISH: begin
        want_emit = 1'b1;
        item.last = 1'b1;
        if (pend_v) begin
          item.status   = ST_FIRED;
          item.timer_id = pend_id;
        end else begin
          item.status = ST_NONE;
        end
      end
      default: begin
        want_emit = 1'b0;
      end
    endcase
    step    = !want_emit || out_free;
    emit    = want_emit && out_free;
    rd_en   = load || ((state == BK_SCAN) && step);
    rd_addr = load ? '0 : idx + IDX_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      idx       <= '0;
      act       <= '0;
      next_id   <= '0;
      pend_v    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        idx    <= '0;
        pend_v <= 1'b0;
      end else if ((state == BK_SCAN) && step) begin
        idx <= idx + 1'b1;
        if (pend_load) begin
          pend_v <= 1'b1;
        end
      end
      if ((state == BK_SCAN) && step && act_set) begin
        act[idx] <= 1'b1;
      end
      if ((state == BK_SCAN) && step && act_clr) begin
        act[idx] <= 1'b0;
      end
      if ((state == BK_SCAN) && step && id_adv) begin
        next_id <= next_id_next;
      end
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= head;
    end
    if ((state == BK_SCAN) && step && pend_load) begin
      pend_id <= rd.id;
    end
    if (emit) begin
      rsp <= item;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == BK_SCAN) && step && wr_en) begin
      slot_mem[idx] <= wr_data;
    end
    if (rd_en) begin
      rd <= slot_mem[rd_addr];
    end
  end

  `MSTT_ASSERT(a_emit_free, !(emit && rsp_valid && rsp_stall), "result overwrites held transfer")
  `MSTT_ASSERT(a_pop_idle, !(pop && (state != BK_IDLE)), "queue popped outside idle")
  `MSTT_ASSERT_NEXT(a_finish_last, (state == BK_FINISH) && step, rsp_valid && rsp.last, "tick end not marked last")

endmodule

@@ rtl/core/multi_slot_timer_table.sv @@
// Timer table with NUM_SLOTS one-shot or periodic slots, counted in microseconds. A front stage
// checks each command transfer and tracks the tick stamp, a two-entry queue hands the checked
// job to the back end, and the back end walks the slot memory one slot per cycle while no
// result holds it. A start or cancel walk ends at the first free or matching slot or at the
// last slot, a counted tick walks every slot and then a finish step, and a command that needs
// no slot (rejected duration, cancel of id 0, first or repeated tick stamp, unused operation)
// is answered from the queue head. Results leave through an output register, so a held result
// does not stop the front stage from taking the next command until the queue is full.
module multi_slot_timer_table #(
  parameter int NUM_SLOTS = mstt_pkg::NUM_SLOTS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  mstt_pkg::cmd_t cmd,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output mstt_pkg::rsp_t rsp
);
  import mstt_pkg::*;

  q_status_t q_status;
  logic      push;
  logic      pop;
  job_t      wr_job;
  job_t      head;

  mstt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .q_status  (q_status),
    .push      (push),
    .job       (wr_job)
  );

  mstt_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .rd_job (head),
    .status (q_status)
  );

  mstt_back #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .head      (head),
    .pop       (pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
